// ===== sv/emahq_pkg.sv =====
// Shared types and constants for the EMA hysteresis quantizer.
package emahq_pkg;

  localparam int SAMPLE_W = 12;
  localparam int FRAC_W   = 16;
  localparam int ACC_W    = SAMPLE_W + FRAC_W;
  localparam int ALPHA_W  = 17;
  localparam int HYST_W   = 4;
  localparam int LEVEL_W  = 8;
  localparam int FS_W     = 16;
  // band arithmetic: level << 11 plus margin fits in 20 bits
  localparam int BAND_W   = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ALPHA_W;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
  localparam logic [HYST_W-1:0]  HYST_MIN    = HYST_W'(4);
  localparam logic [HYST_W-1:0]  HYST_MAX    = HYST_W'(11);
  localparam logic [HYST_W-1:0]  HYST_RESET  = HYST_W'(5);
  localparam logic [LEVEL_W-1:0] LEVEL_LIMIT = {LEVEL_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HYST  = 1'b1;

  // effective (clamped) configuration
  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [HYST_W-1:0]  hyst;
  } cfg_t;

  // pipeline stage control: load from upstream, unload to downstream
  typedef struct packed {
    logic load;
    logic unload;
  } stage_ctl_t;

endpackage

// ===== sv/emahq_filter.sv =====
// Filter stage: saturation and exponential moving average update.
module emahq_filter #(
  parameter int FULL_SCALE = 4095
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  emahq_pkg::stage_ctl_t                ctl,
  input  logic [emahq_pkg::SAMPLE_W-1:0]       sample,
  input  logic [emahq_pkg::ALPHA_W-1:0]        alpha,
  output logic                                 valid,
  output logic [emahq_pkg::SAMPLE_W-1:0]       ipart
);
  import emahq_pkg::*;

  localparam logic [FS_W-1:0] FS = FS_W'(FULL_SCALE);

  logic [ACC_W-1:0]           smoothed;
  logic [ACC_W-1:0]           smoothed_next;
  logic [SAMPLE_W-1:0]        sample_sat;
  logic [ACC_W-1:0]           target;
  logic                       rising;
  logic [ACC_W-1:0]           diff;
  logic [ACC_W+ALPHA_W-1:0]   prod;
  logic [ACC_W-1:0]           step;

  // saturate to full scale, then move toward the target by alpha
  always_comb begin
    sample_sat = ({{(FS_W-SAMPLE_W){1'b0}}, sample} > FS) ? FS[SAMPLE_W-1:0] : sample;
    target     = {sample_sat, {FRAC_W{1'b0}}};
    rising     = (target >= smoothed);
    diff       = rising ? (target - smoothed) : (smoothed - target);
    prod       = {{ALPHA_W{1'b0}}, diff} * {{ACC_W{1'b0}}, alpha};
    // step never exceeds diff, so the upper bits are zero
    step       = prod[ACC_W+FRAC_W-1:FRAC_W];
    smoothed_next = rising ? (smoothed + step) : (smoothed - step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      valid    <= 1'b0;
    end else if (ctl.load) begin
      smoothed <= smoothed_next;
      valid    <= 1'b1;
    end else if (ctl.unload) begin
      valid    <= 1'b0;
    end
  end

  // integer part, held with the smoothed value until this stage unloads
  assign ipart = smoothed[ACC_W-1:FRAC_W];

endmodule

// ===== sv/emahq_quant.sv =====
// Quantizer stage: hysteresis band check, level register and result register.
module emahq_quant #(
  parameter int FULL_SCALE = 4095
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  emahq_pkg::stage_ctl_t                ctl,
  input  logic [emahq_pkg::SAMPLE_W-1:0]       ipart,
  input  logic [emahq_pkg::HYST_W-1:0]         hyst,
  output logic                                 valid,
  output logic                                 changed,
  output logic [emahq_pkg::LEVEL_W-1:0]        level
);
  import emahq_pkg::*;

  localparam logic [FS_W-1:0] FS = FS_W'(FULL_SCALE);

  logic [FS_W-1:0]     top_wide;
  logic [LEVEL_W-1:0]  top;
  logic [BAND_W-1:0]   margin;
  logic [BAND_W-1:0]   center;
  logic [BAND_W-1:0]   lower;
  logic [BAND_W-1:0]   upper;
  logic [BAND_W-1:0]   ipart_w;
  logic                outside;
  logic [SAMPLE_W-1:0] coarse;
  logic [LEVEL_W-1:0]  level_next;

  // band around the current level's center, widened at both ends
  always_comb begin
    top_wide = FS >> hyst;
    top      = (top_wide > {{(FS_W-LEVEL_W){1'b0}}, LEVEL_LIMIT}) ?
               LEVEL_LIMIT : top_wide[LEVEL_W-1:0];
    margin   = (BAND_W'(1) << hyst) - BAND_W'(1);
    center   = ({{(BAND_W-LEVEL_W){1'b0}}, level} << hyst) |
               (BAND_W'(1) << (hyst - HYST_W'(1)));
    lower    = (level != '0) ? (center - margin) : '0;
    upper    = (level < top) ? (center + margin) : {{(BAND_W-FS_W){1'b0}}, FS};
    ipart_w  = {{(BAND_W-SAMPLE_W){1'b0}}, ipart};
    outside  = (ipart_w < lower) || (ipart_w > upper);
    coarse   = ipart >> hyst;
    if (!outside) begin
      level_next = level;
    end else if (coarse > {{(SAMPLE_W-LEVEL_W){1'b0}}, top}) begin
      level_next = top;
    end else begin
      level_next = coarse[LEVEL_W-1:0];
    end
  end

  // level only moves on load, so it also serves as the held result field
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      valid <= 1'b0;
    end else if (ctl.load) begin
      level <= level_next;
      valid <= 1'b1;
    end else if (ctl.unload) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      changed <= outside;
    end
  end

endmodule

// ===== sv/ema_hysteresis_quantizer_core.sv =====
// Top level of the EMA hysteresis quantizer: handshake, config and stages.
//
// Input channel: sample with in_valid/in_stall; a transaction completes at a
// rising edge with in_valid high and in_stall low. Output channel: changed and
// level with out_valid/out_stall, one result per input sample, in order.
// Configuration: cfg_we with cfg_index (0 = alpha_q16, 1 = level shift) and
// cfg_data; write only while no sample is in flight. Other indexes are ignored.
// Pipeline: input register, filter stage (smoothed value register, one
// 28x17 multiply), quantizer stage (level register and result register).
// out_valid rises once a sample has passed the input register, the filter
// stage and the quantizer stage. Throughput is one sample per cycle while
// out_stall is low; the smoothed value and the level each close a loop on
// their own register. Each stage advances when the next one is empty or
// draining, so bubbles collapse and samples keep being accepted while a
// finished result waits; in_stall rises only when all three stages are full
// and out_stall is high. A stalled result holds its fields.
// Reset (rst, synchronous): pipeline empty, smoothed value and level zero,
// alpha_q16 = 65536 (no filtering), level shift = 5.
module ema_hysteresis_quantizer_core #(
  parameter int FULL_SCALE = 4095
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [emahq_pkg::SAMPLE_W-1:0]        sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  changed,
  output logic [emahq_pkg::LEVEL_W-1:0]         level,
  input  logic                                  cfg_we,
  input  logic [emahq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [emahq_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import emahq_pkg::*;

  logic [ALPHA_W-1:0]  alpha_q16;
  logic [HYST_W-1:0]   hyst_shift;
  cfg_t                cfg;

  logic                in_reg_valid;
  logic [SAMPLE_W-1:0] in_reg_sample;
  logic                filt_valid;
  logic [SAMPLE_W-1:0] filt_ipart;
  stage_ctl_t          filt_ctl;
  stage_ctl_t          quant_ctl;
  logic                out_free;
  logic                filt_free;
  logic                in_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q16  <= ALPHA_ONE;
      hyst_shift <= HYST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHA: alpha_q16  <= cfg_data[ALPHA_W-1:0];
        REG_HYST:  hyst_shift <= cfg_data[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the usable ranges
  always_comb begin
    cfg.alpha = (alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : alpha_q16;
    if (hyst_shift < HYST_MIN) begin
      cfg.hyst = HYST_MIN;
    end else if (hyst_shift > HYST_MAX) begin
      cfg.hyst = HYST_MAX;
    end else begin
      cfg.hyst = hyst_shift;
    end
  end

  // stage flow control
  always_comb begin
    out_free         = !out_valid || !out_stall;
    quant_ctl.load   = filt_valid && out_free;
    quant_ctl.unload = out_valid && !out_stall;
    filt_free        = !filt_valid || out_free;
    filt_ctl.load    = in_reg_valid && filt_free;
    filt_ctl.unload  = quant_ctl.load;
    in_free          = !in_reg_valid || filt_free;
  end

  assign in_stall = !in_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_free) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_valid) begin
      in_reg_sample <= sample;
    end
  end

  emahq_filter #(
    .FULL_SCALE (FULL_SCALE)
  ) u_filter (
    .clk    (clk),
    .rst    (rst),
    .ctl    (filt_ctl),
    .sample (in_reg_sample),
    .alpha  (cfg.alpha),
    .valid  (filt_valid),
    .ipart  (filt_ipart)
  );

  emahq_quant #(
    .FULL_SCALE (FULL_SCALE)
  ) u_quant (
    .clk     (clk),
    .rst     (rst),
    .ctl     (quant_ctl),
    .ipart   (filt_ipart),
    .hyst    (cfg.hyst),
    .valid   (out_valid),
    .changed (changed),
    .level   (level)
  );

endmodule
